@@ rtl/core/strmm_pkg.sv @@
// Shared types, constants and state encoding for the sparse-table range min/max engine.
// Depends on nothing; used by every module of the block.
package strmm_pkg;

    localparam int unsigned MaxElements = 1024;
    localparam int unsigned Levels      = 11;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_BAD  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
        logic [10:0]        left;
        logic [10:0]        right;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] range_min;
        logic signed [31:0] range_max;
        logic [1:0]         status;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BLD_RD,
        ST_BLD_WAIT,
        ST_BLD_WR,
        ST_Q_RD0,
        ST_Q_RD1,
        ST_Q_WAIT,
        ST_Q_DONE,
        ST_OUT
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load_in;
        logic do_append;
        logic do_clear;
        logic set_built;
        logic bld_start;
        logic bld_read;
        logic bld_write;
        logic bld_next;
        logic q_setup;
        logic q_read0;
        logic q_read1;
        logic q_finish;
        logic res_bad;
        logic res_full;
        logic res_append;
        logic out_take;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       bad_range;
        logic       built;
        logic       bld_empty;
        logic       bld_last;
    } stat_t;

endpackage

@@ rtl/core/sparse_table_range_min_max.sv @@
// Top level of the sparse-table range min/max engine.
// Depends on strmm_pkg, strmm_ctrl and strmm_dp.
//
// Usage:
//   s_ channel carries one beat: kind (append, query, clear), value, left, right.
//   m_ channel returns range_min, range_max and status for append and query
//   beats; clear and the unused kind return nothing.
//   One beat is handled at a time. An append, a refused append or a bad-range
//   query answers straight after decode; a query on a built table first reads
//   two entries of one level and combines them. The first in-range query after
//   an accepted append or a clear first rebuilds levels 1 to LEVELS-1 as far as
//   the count reaches: each entry reads its low half, then its high half,
//   through the single read port of each table memory, and is written last.
//   After the result is taken the engine goes idle before the next beat.
//   Reset empties the array and marks the table unbuilt; the memories keep
//   no defined contents until written. A stalled result simply holds in its
//   output register, and s_ready stays low until it is taken.
module sparse_table_range_min_max #(
    parameter int unsigned MAX_ELEMENTS = strmm_pkg::MaxElements,
    parameter int unsigned LEVELS       = strmm_pkg::Levels
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  strmm_pkg::in_beat_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output strmm_pkg::out_beat_t  m_data
);

    strmm_pkg::cmd_t  cmd;
    strmm_pkg::stat_t stat;

    strmm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    strmm_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LEVELS       (LEVELS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

@@ rtl/core/strmm_ctrl.sv @@
// Controller state machine: sequences append, clear, rebuild and query beats.
// Depends on strmm_pkg.
module strmm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  strmm_pkg::stat_t   stat,
    output strmm_pkg::cmd_t    cmd
);

    strmm_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= strmm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            strmm_pkg::ST_IDLE: begin
                if (s_valid) state_next = strmm_pkg::ST_DECODE;
            end
            strmm_pkg::ST_DECODE: begin
                case (stat.kind)
                    strmm_pkg::KIND_APPEND: state_next = strmm_pkg::ST_OUT;
                    strmm_pkg::KIND_QUERY: begin
                        if (stat.bad_range)  state_next = strmm_pkg::ST_OUT;
                        else if (stat.built) state_next = strmm_pkg::ST_Q_RD0;
                        else                 state_next = strmm_pkg::ST_BLD_RD;
                    end
                    default: state_next = strmm_pkg::ST_IDLE;
                endcase
            end
            strmm_pkg::ST_BLD_RD: begin
                if (stat.bld_empty) state_next = strmm_pkg::ST_Q_RD0;
                else                state_next = strmm_pkg::ST_BLD_WAIT;
            end
            strmm_pkg::ST_BLD_WAIT: state_next = strmm_pkg::ST_BLD_WR;
            strmm_pkg::ST_BLD_WR: begin
                if (stat.bld_last) state_next = strmm_pkg::ST_Q_RD0;
                else               state_next = strmm_pkg::ST_BLD_RD;
            end
            strmm_pkg::ST_Q_RD0:  state_next = strmm_pkg::ST_Q_RD1;
            strmm_pkg::ST_Q_RD1:  state_next = strmm_pkg::ST_Q_WAIT;
            strmm_pkg::ST_Q_WAIT: state_next = strmm_pkg::ST_Q_DONE;
            strmm_pkg::ST_Q_DONE: state_next = strmm_pkg::ST_OUT;
            strmm_pkg::ST_OUT: begin
                if (m_ready) state_next = strmm_pkg::ST_IDLE;
            end
            default: state_next = strmm_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            strmm_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            strmm_pkg::ST_DECODE: begin
                case (stat.kind)
                    strmm_pkg::KIND_APPEND: begin
                        cmd.do_append  = !stat.full;
                        cmd.res_full   = stat.full;
                        cmd.res_append = !stat.full;
                    end
                    strmm_pkg::KIND_QUERY: begin
                        cmd.res_bad   = stat.bad_range;
                        cmd.bld_start = !stat.bad_range && !stat.built;
                        cmd.q_setup   = !stat.bad_range && stat.built;
                    end
                    strmm_pkg::KIND_CLEAR: cmd.do_clear = 1'b1;
                    default: ;
                endcase
            end
            strmm_pkg::ST_BLD_RD: begin
                cmd.bld_read  = !stat.bld_empty;
                cmd.set_built = stat.bld_empty;
                cmd.q_setup   = stat.bld_empty;
            end
            strmm_pkg::ST_BLD_WAIT: ;
            strmm_pkg::ST_BLD_WR: begin
                cmd.bld_write = 1'b1;
                cmd.bld_next  = 1'b1;
                cmd.set_built = stat.bld_last;
                cmd.q_setup   = stat.bld_last;
            end
            strmm_pkg::ST_Q_RD0:  cmd.q_read0 = 1'b1;
            strmm_pkg::ST_Q_RD1:  cmd.q_read1 = 1'b1;
            strmm_pkg::ST_Q_WAIT: ;
            strmm_pkg::ST_Q_DONE: cmd.q_finish = 1'b1;
            strmm_pkg::ST_OUT: begin
                m_valid      = 1'b1;
                cmd.out_take = m_ready;
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/core/strmm_dp.sv @@
// Datapath: element count, sparse-table memories, rebuild walker and query combine.
// Depends on strmm_pkg.
module strmm_dp #(
    parameter int unsigned MAX_ELEMENTS = strmm_pkg::MaxElements,
    parameter int unsigned LEVELS       = strmm_pkg::Levels
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  strmm_pkg::in_beat_t   s_data,
    output strmm_pkg::out_beat_t  m_data,
    input  strmm_pkg::cmd_t       cmd,
    output strmm_pkg::stat_t      stat
);

    localparam int unsigned PW    = $clog2(MAX_ELEMENTS);
    localparam int unsigned CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned LW    = $clog2(LEVELS);
    localparam int unsigned Depth = MAX_ELEMENTS * LEVELS;
    localparam int unsigned AW    = $clog2(Depth);

    logic signed [31:0] min_mem [Depth];
    logic signed [31:0] max_mem [Depth];

    strmm_pkg::in_beat_t  in_reg;
    strmm_pkg::out_beat_t out_reg;
    logic [CW-1:0]        count_reg;
    logic                 built_reg;

    // Rebuild walker
    logic [LW-1:0] lvl_reg;
    logic [CW-1:0] pos_reg;
    logic          phase_reg;
    logic signed [31:0] amin_reg, amax_reg;
    logic signed [31:0] rmin_reg, rmax_reg;

    // Query
    logic [LW-1:0] qk_reg;
    logic [PW-1:0] ql_reg, qr_reg;

    logic [AW-1:0] rd_addr, wr_addr;
    logic          rd_en;
    logic          wr_en;
    logic signed [31:0] wmin, wmax;

    function automatic logic [AW-1:0] addr_of(logic [LW-1:0] lv, logic [PW-1:0] p);
        logic [AW+LW:0] a;
        a = AW'(lv) * (AW+LW+1)'(MAX_ELEMENTS) + (AW+LW+1)'(p);
        return a[AW-1:0];
    endfunction

    // Checks on the held beat
    logic [CW:0] rgt;
    assign rgt = (CW+1)'(in_reg.right);

    assign stat.kind      = in_reg.kind;
    assign stat.full      = (count_reg == CW'(MAX_ELEMENTS));
    assign stat.bad_range = (in_reg.left == '0) || (in_reg.left > in_reg.right)
                         || (rgt > (CW+1)'(count_reg));
    assign stat.built     = built_reg;

    // Rebuild bounds: level lvl exists while 2^lvl <= count and lvl < LEVELS
    logic [CW+1:0] span, span_next;
    assign span = (CW+2)'(1) << lvl_reg;
    assign span_next = (CW+2)'(1) << (lvl_reg + LW'(1));
    assign stat.bld_empty = (phase_reg == 1'b0) &&
                            (span > (CW+2)'(count_reg) || lvl_reg == '0);
    logic lvl_end, last_lvl;
    assign lvl_end  = ((CW+2)'(pos_reg) + span + (CW+2)'(1)) > (CW+2)'(count_reg);
    assign last_lvl = (32'(lvl_reg) + 1 >= LEVELS) || (span_next > (CW+2)'(count_reg));
    // Only the high-half pass writes the entry, so finish there
    assign stat.bld_last = phase_reg && lvl_end && last_lvl;

    // Query window level: floor(log2(len)) capped at LEVELS-1
    logic [PW:0]   qlen;
    logic [LW-1:0] qk;
    assign qlen = (PW+1)'(in_reg.right) - (PW+1)'(in_reg.left) + (PW+1)'(1);
    always_comb begin
        qk = '0;
        for (int i = 1; i < LEVELS; i++) begin
            if (32'(qlen) >= (32'd1 << i)) qk = LW'(i);
        end
    end

    // Memory addressing
    logic [PW-1:0] half;
    assign half = PW'((CW+2)'(1) << (lvl_reg - LW'(1)));
    assign rd_en = cmd.bld_read || cmd.q_read0 || cmd.q_read1;
    always_comb begin
        rd_addr = '0;
        if (cmd.bld_read) begin
            if (!phase_reg) rd_addr = addr_of(lvl_reg - LW'(1), PW'(pos_reg));
            else            rd_addr = addr_of(lvl_reg - LW'(1), PW'(pos_reg) + half);
        end else if (cmd.q_read0) begin
            rd_addr = addr_of(qk_reg, ql_reg);
        end else begin
            rd_addr = addr_of(qk_reg, qr_reg);
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr_of('0, PW'(count_reg));
        wmin    = in_reg.value;
        wmax    = in_reg.value;
        if (cmd.do_append) begin
            wr_en = 1'b1;
        end else if (cmd.bld_write && phase_reg) begin
            wr_en   = 1'b1;
            wr_addr = addr_of(lvl_reg, PW'(pos_reg));
            wmin    = (amin_reg < rmin_reg) ? amin_reg : rmin_reg;
            wmax    = (amax_reg > rmax_reg) ? amax_reg : rmax_reg;
        end
    end

    // Table memories; read data holds until the next read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            min_mem[wr_addr] <= wmin;
            max_mem[wr_addr] <= wmax;
        end
        if (rd_en) begin
            rmin_reg <= min_mem[rd_addr];
            rmax_reg <= max_mem[rd_addr];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            built_reg <= 1'b0;
            lvl_reg   <= '0;
            pos_reg   <= '0;
            phase_reg <= 1'b0;
        end else begin
            if (cmd.do_append) begin
                count_reg <= count_reg + CW'(1);
                built_reg <= 1'b0;
            end
            if (cmd.do_clear) begin
                count_reg <= '0;
                built_reg <= 1'b0;
            end
            if (cmd.set_built) built_reg <= 1'b1;
            if (cmd.bld_start) begin
                lvl_reg   <= LW'(1);
                pos_reg   <= '0;
                phase_reg <= 1'b0;
            end
            // Each entry: read the low half, then the high half, which writes the entry
            if (cmd.bld_next) begin
                if (!phase_reg) begin
                    phase_reg <= 1'b1;
                end else begin
                    phase_reg <= 1'b0;
                    if (lvl_end) begin
                        pos_reg <= '0;
                        lvl_reg <= lvl_reg + LW'(1);
                    end else begin
                        pos_reg <= pos_reg + CW'(1);
                    end
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) in_reg <= s_data;
        if (cmd.bld_write && !phase_reg) begin
            amin_reg <= rmin_reg;
            amax_reg <= rmax_reg;
        end
        if (cmd.q_setup) begin
            qk_reg <= qk;
            ql_reg <= PW'(in_reg.left - 11'd1);
            qr_reg <= PW'(in_reg.right - (11'd1 << qk));
        end
        if (cmd.q_read1) begin
            amin_reg <= rmin_reg;
            amax_reg <= rmax_reg;
        end
        if (cmd.res_bad)    out_reg <= '{32'sd0, 32'sd0, strmm_pkg::STATUS_BAD};
        if (cmd.res_full)   out_reg <= '{32'sd0, 32'sd0, strmm_pkg::STATUS_FULL};
        if (cmd.res_append) out_reg <= '{32'sd0, 32'sd0, strmm_pkg::STATUS_OK};
        if (cmd.q_finish) begin
            out_reg.range_min <= (amin_reg < rmin_reg) ? amin_reg : rmin_reg;
            out_reg.range_max <= (amax_reg > rmax_reg) ? amax_reg : rmax_reg;
            out_reg.status    <= strmm_pkg::STATUS_OK;
        end
    end

    assign m_data = out_reg;

endmodule

@@ rtl/core/strmm_checker.sv @@
// Port-level checker for the sparse-table range min/max engine, bound to the top.
// Depends on strmm_pkg.
module strmm_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input strmm_pkg::out_beat_t  m_data
);

    // Never take an input beat while a result is still pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");

    // A held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped or changed under stall");

    // Status never shows the unused code
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status != 2'd3)) else $error("bad status code");

    // Non-ok results carry zero values
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != strmm_pkg::STATUS_OK) |->
        (m_data.range_min == 0 && m_data.range_max == 0))
        else $error("error result carries data");

    // No result directly after an accepted beat
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid) else $error("result too early");

endmodule

bind sparse_table_range_min_max strmm_checker u_strmm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ sim/sparse_table_range_min_max_tb.sv @@
// Testbench for the sparse-table range min/max engine: directed table, overfill,
// then random append/query/clear runs checked by a scan-based range predictor.
// Depends on strmm_pkg and sparse_table_range_min_max.
`timescale 1ns / 1ps

module sparse_table_range_min_max_tb;

    localparam int unsigned StallLimit = 200000;

    typedef struct {
        strmm_pkg::in_beat_t  beat;
        bit                   fixed;
        strmm_pkg::out_beat_t want;
    } row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    strmm_pkg::in_beat_t  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    strmm_pkg::out_beat_t m_data;

    // predictor state: plain copy of the stored elements
    logic signed [31:0]   stored_vals [strmm_pkg::MaxElements];
    int unsigned          stored_count = 0;
    strmm_pkg::out_beat_t pending_results [$];
    int unsigned          errors = 0;
    int unsigned          results_seen = 0;
    int unsigned          idle_cycles = 0;
    int unsigned          items_sent = 0;
    int unsigned          hold_left = 0;
    bit                   hold_done = 1'b0;
    bit                   stim_done = 1'b0;

    sparse_table_range_min_max dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Work out the answer to one beat and update the stored elements
    function automatic bit range_answer(input strmm_pkg::in_beat_t b,
                                        output strmm_pkg::out_beat_t res);
        logic signed [31:0] lo, hi;
        res = '0;
        case (b.kind)
            strmm_pkg::KIND_APPEND: begin
                if (stored_count >= strmm_pkg::MaxElements) begin
                    res.status = strmm_pkg::STATUS_FULL;
                end else begin
                    stored_vals[stored_count] = b.value;
                    stored_count++;
                    res.status = strmm_pkg::STATUS_OK;
                end
                return 1'b1;
            end
            strmm_pkg::KIND_QUERY: begin
                if (b.left == 0 || b.left > b.right || b.right > stored_count) begin
                    res.status = strmm_pkg::STATUS_BAD;
                    return 1'b1;
                end
                lo = stored_vals[b.left - 1];
                hi = lo;
                for (int i = b.left; i < b.right; i++) begin
                    if (stored_vals[i] < lo) lo = stored_vals[i];
                    if (stored_vals[i] > hi) hi = stored_vals[i];
                end
                res.range_min = lo;
                res.range_max = hi;
                res.status    = strmm_pkg::STATUS_OK;
                return 1'b1;
            end
            strmm_pkg::KIND_CLEAR: begin
                stored_count = 0;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Mostly no gap, some short, a few long; every other stretch of 200 has none
    function automatic int unsigned gap_len(input int unsigned phase);
        int unsigned r;
        r = $urandom_range(0, 99);
        if ((phase / 200) % 2 == 0) return 0;
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one beat, hold it until taken, then predict and idle for any gap drawn
    task automatic send_beat(input strmm_pkg::in_beat_t b, input bit fixed,
                             input strmm_pkg::out_beat_t want);
        strmm_pkg::out_beat_t res;
        bit                   has;
        int unsigned          gap;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        has = range_answer(b, res);
        if (has) pending_results.push_back(fixed ? want : res);
        items_sent++;
        gap = gap_len(items_sent);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    function automatic strmm_pkg::in_beat_t mk(input logic [1:0] kind,
                                               input logic signed [31:0] value,
                                               input logic [10:0] left,
                                               input logic [10:0] right);
        strmm_pkg::in_beat_t b;
        b.kind  = kind;
        b.value = value;
        b.left  = left;
        b.right = right;
        return b;
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_plain(input strmm_pkg::in_beat_t b);
        send_beat(b, 1'b0, '0);
    endtask

    // Valid query range for the current element count
    task automatic send_good_query();
        int unsigned l, r;
        l = $urandom_range(1, stored_count);
        r = $urandom_range(l, stored_count);
        if ($urandom_range(0, 5) == 0) begin
            l = 1;
            r = stored_count;
        end
        send_plain(mk(strmm_pkg::KIND_QUERY, $urandom, 11'(l), 11'(r)));
    endtask

    // Directed stimulus, then random sequences
    initial begin
        row_t                 rows [$];
        strmm_pkg::out_beat_t bad_res, ok_res;
        int unsigned          n;
        bad_res = '0;
        bad_res.status = strmm_pkg::STATUS_BAD;
        ok_res = '0;
        ok_res.status = strmm_pkg::STATUS_OK;

        rows.push_back('{mk(strmm_pkg::KIND_QUERY, 0, 1, 1), 1'b1, bad_res});
        rows.push_back('{mk(strmm_pkg::KIND_APPEND, 32'sh7FFF_FFFF, 0, 0), 1'b1, ok_res});
        rows.push_back('{mk(strmm_pkg::KIND_APPEND, 32'sh8000_0000, 2047, 2047), 1'b1,
                         ok_res});
        rows.push_back('{mk(strmm_pkg::KIND_APPEND, 0, 0, 0), 1'b1, ok_res});
        rows.push_back('{mk(strmm_pkg::KIND_APPEND, -1, 0, 0), 1'b1, ok_res});
        rows.push_back('{mk(strmm_pkg::KIND_APPEND, 5, 0, 0), 1'b1, ok_res});
        rows.push_back('{mk(strmm_pkg::KIND_QUERY, -1, 1, 5), 1'b0, '0});
        rows.push_back('{mk(strmm_pkg::KIND_QUERY, 0, 2, 2), 1'b0, '0});
        rows.push_back('{mk(strmm_pkg::KIND_QUERY, 0, 3, 5), 1'b0, '0});
        rows.push_back('{mk(strmm_pkg::KIND_QUERY, 0, 1, 4), 1'b0, '0});
        rows.push_back('{mk(strmm_pkg::KIND_QUERY, 0, 0, 3), 1'b1, bad_res});
        rows.push_back('{mk(strmm_pkg::KIND_QUERY, 0, 4, 3), 1'b1, bad_res});
        rows.push_back('{mk(strmm_pkg::KIND_QUERY, 0, 1, 6), 1'b1, bad_res});
        rows.push_back('{mk(strmm_pkg::KIND_QUERY, 0, 2047, 2047), 1'b1, bad_res});
        rows.push_back('{mk(strmm_pkg::KIND_UNUSED, 7, 1, 1), 1'b0, '0});
        rows.push_back('{mk(strmm_pkg::KIND_CLEAR, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk(strmm_pkg::KIND_QUERY, 0, 1, 1), 1'b1, bad_res});
        rows.push_back('{mk(strmm_pkg::KIND_APPEND, 42, 0, 0), 1'b1, ok_res});
        rows.push_back('{mk(strmm_pkg::KIND_QUERY, 0, 1, 1), 1'b0, '0});

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) send_beat(rows[i].beat, rows[i].fixed, rows[i].want);

        // fill the array to its limit once, then overflow it
        send_plain(mk(strmm_pkg::KIND_CLEAR, 0, 0, 0));
        repeat (strmm_pkg::MaxElements)
            send_plain(mk(strmm_pkg::KIND_APPEND, rand_value(), 0, 0));
        repeat (2) send_plain(mk(strmm_pkg::KIND_APPEND, rand_value(), 0, 0));
        send_plain(mk(strmm_pkg::KIND_QUERY, 0, 1, 11'(strmm_pkg::MaxElements)));
        send_plain(mk(strmm_pkg::KIND_QUERY, 0, 11'(strmm_pkg::MaxElements),
                      11'(strmm_pkg::MaxElements)));
        repeat (10) send_good_query();

        while (items_sent < 2000) begin
            if ($urandom_range(0, 4) != 0) begin
                // well-formed sequence: clear, load, query
                send_plain(mk(strmm_pkg::KIND_CLEAR, $urandom, 11'($urandom),
                              11'($urandom)));
                n = $urandom_range(0, 19) == 0 ? $urandom_range(33, 200)
                                               : $urandom_range(1, 32);
                repeat (n)
                    send_plain(mk(strmm_pkg::KIND_APPEND, rand_value(), 11'($urandom),
                                  11'($urandom)));
                repeat ($urandom_range(3, 12)) begin
                    if ($urandom_range(0, 7) == 0)
                        send_plain(mk(strmm_pkg::KIND_QUERY, $urandom, 11'($urandom),
                                      11'($urandom)));
                    else
                        send_good_query();
                end
            end else begin
                // noise: any kind, any field values
                repeat ($urandom_range(1, 8))
                    send_plain(mk(2'($urandom_range(0, 3)), $urandom, 11'($urandom),
                                  11'($urandom)));
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        stim_done = 1'b1;
        wait (pending_results.size() == 0);
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Readiness: one long hold-off, else always-ready and random-stall stretches
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (!hold_done && results_seen >= 60) begin
                hold_done = 1'b1;
                hold_left = 3000;
                m_ready <= 1'b0;
            end else if ((results_seen / 150) % 2 == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) < 70);
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        strmm_pkg::out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.range_min !== want.range_min) begin
                    $display("%0t: range_min expected %0d got %0d", $time,
                             want.range_min, m_data.range_min);
                    errors++;
                end
                if (m_data.range_max !== want.range_max) begin
                    $display("%0t: range_max expected %0d got %0d", $time,
                             want.range_max, m_data.range_max);
                    errors++;
                end
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time,
                             want.status, m_data.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run after too long without any beat moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule
